@@ src/mrt_pkg.sv @@
// shared types, codes and constants of the mesh route table
package mrt_pkg;

	// node number width on the stream and memory address width
	localparam int NodeW = 8;

	// time constants for ageing
	localparam int unsigned MsPerSec = 1000;
	localparam int unsigned SecPerMin = 60;
	localparam int unsigned MsPerMin = MsPerSec * SecPerMin;
	localparam int ThrW = 24;

	// stream widths, padded to whole bytes
	localparam int InBits = 96;
	localparam int OutBits = 56;

	// operation codes
	localparam logic [1:0] FnPacket = 2'd0;
	localparam logic [1:0] FnAnnounce = 2'd1;
	localparam logic [1:0] FnLookup = 2'd2;
	localparam logic [1:0] FnSweep = 2'd3;

	// status codes
	localparam logic [2:0] StsOk = 3'd0;
	localparam logic [2:0] StsError = 3'd1;
	localparam logic [2:0] StsBetter = 3'd2;
	localparam logic [2:0] StsWorse = 3'd3;
	localparam logic [2:0] StsUpdated = 3'd4;

	// configuration register indexes
	localparam logic [1:0] CfgOwnNode = 2'd0;
	localparam logic [1:0] CfgTtlStart = 2'd1;
	localparam logic [1:0] CfgInactive = 2'd2;
	localparam logic [1:0] CfgBroadcast = 2'd3;

	// configuration reset values
	localparam logic [4:0] OwnNodeReset = 5'd1;
	localparam logic [7:0] TtlStartReset = 8'd5;
	localparam logic [ThrW-1:0] ThrReset = ThrW'(5 * MsPerMin);
	localparam logic [7:0] BroadcastReset = 8'd255;

	// input item, first field in the highest bits
	typedef struct packed {
		logic [1:0] func;
		logic [7:0] destination;
		logic [31:0] now_ms;
		logic signed [8:0] rssi;
		logic [15:0] packet_id;
		logic [7:0] ttl;
		logic [7:0] last_hop;
		logic [7:0] sender;
	} item_t;

	// result item, first field in the highest bits
	typedef struct packed {
		logic [4:0] removed_count;
		logic is_active;
		logic [15:0] seen_id;
		logic signed [8:0] link_rssi;
		logic [7:0] hop_count;
		logic [7:0] next_hop;
		logic [2:0] status;
	} result_t;

	// one stored route
	typedef struct packed {
		logic [7:0] next_hop;
		logic [7:0] hops;
		logic [15:0] id;
		logic signed [8:0] rssi;
		logic [31:0] seen;
	} route_entry_t;

	// memory access request
	typedef struct packed {
		logic rd_en;
		logic [NodeW-1:0] rd_addr;
		logic wr_en;
		logic [NodeW-1:0] wr_addr;
		route_entry_t wr_data;
	} mem_req_t;

	// configuration as seen by the sequencer
	typedef struct packed {
		logic [4:0] own_node;
		logic [7:0] ttl_start;
		logic [ThrW-1:0] thr_ms;
		logic [7:0] broadcast_addr;
	} cfg_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_LHOP,
		ST_SEND_RD,
		ST_SEND_WR,
		ST_ANN,
		ST_LOOK,
		ST_SWEEP,
		ST_DONE
	} state_t;

	// node number in 1..nodes
	function automatic logic node_ok(logic [NodeW-1:0] n, logic [NodeW-1:0] nodes);
		return (n != '0) && (n <= nodes);
	endfunction

	// table index that belongs to the own node
	function automatic logic is_own(logic [NodeW-1:0] idx, logic [4:0] own);
		return ({1'b0, idx} + 9'd1) == 9'(own);
	endfunction

endpackage

@@ src/mrt_store.sv @@
// route memory: one write and one registered read port, entries read zero until written
module mrt_store #(
	parameter int NODES = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  mrt_pkg::mem_req_t req,
	output mrt_pkg::route_entry_t rd_data
);
	localparam int IW = $clog2(NODES);

	mrt_pkg::route_entry_t mem_q [NODES];
	logic [NODES-1:0] valid_q;
	mrt_pkg::route_entry_t rdata_s1;
	logic rvalid_q;

	// memory array write and read
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr[IW-1:0]] <= req.wr_data;
		end
		if (req.rd_en) begin
			rdata_s1 <= mem_q[req.rd_addr[IW-1:0]];
		end
	end

	// written marks, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				valid_q[req.wr_addr[IW-1:0]] <= 1'b1;
			end
			if (req.rd_en) begin
				rvalid_q <= valid_q[req.rd_addr[IW-1:0]];
			end
		end
	end

	assign rd_data = rvalid_q ? rdata_s1 : '0;

endmodule

@@ src/mrt_seq.sv @@
// sequencer: decodes an item, reads, modifies and writes back route entries
module mrt_seq #(
	parameter int NODES = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  mrt_pkg::item_t in_item,
	input  mrt_pkg::cfg_t cfg,
	output logic res_valid,
	input  logic res_take,
	output mrt_pkg::result_t res,
	output mrt_pkg::mem_req_t mem_req,
	input  mrt_pkg::route_entry_t mem_rdata
);
	localparam int IW = $clog2(NODES);
	localparam int CW = $clog2(NODES + 1);
	localparam logic [mrt_pkg::NodeW-1:0] NodesV = mrt_pkg::NodeW'(NODES);
	localparam logic [CW-1:0] CntEnd = CW'(NODES);

	mrt_pkg::state_t state_q, state_d;
	mrt_pkg::item_t item_q;
	mrt_pkg::result_t res_q;
	logic [NODES-1:0] active_q;
	logic [CW-1:0] cnt_q;

	logic [7:0] hops;
	logic [7:0] own8;
	logic from_own;
	logic [mrt_pkg::NodeW-1:0] li, si, di;
	logic li_act, si_act, di_act;
	logic pkt_err;
	logic [CW-1:0] pcnt;
	logic [IW-1:0] pidx;
	logic [31:0] elapsed;
	logic retire;
	logic better;
	logic same_id;
	logic [2:0] ann_status;

	// item decode
	assign hops = (cfg.ttl_start > item_q.ttl) ? (cfg.ttl_start - item_q.ttl) : 8'd0;
	assign own8 = {3'b000, cfg.own_node};
	assign from_own = (item_q.sender == own8);
	assign li = item_q.last_hop - 8'd1;
	assign si = item_q.sender - 8'd1;
	assign di = item_q.destination - 8'd1;
	assign li_act = active_q[li[IW-1:0]] || mrt_pkg::is_own(li, cfg.own_node);
	assign si_act = active_q[si[IW-1:0]] || mrt_pkg::is_own(si, cfg.own_node);
	assign di_act = active_q[di[IW-1:0]] || mrt_pkg::is_own(di, cfg.own_node);
	assign pkt_err = !mrt_pkg::node_ok(item_q.last_hop, NodesV)
		|| ((hops != 8'd0) && !from_own && !mrt_pkg::node_ok(item_q.sender, NodesV));

	// sweep: entry whose read data is arriving this cycle
	assign pcnt = cnt_q - CW'(1);
	assign pidx = pcnt[IW-1:0];
	assign elapsed = item_q.now_ms - mem_rdata.seen;
	assign retire = active_q[pidx] && !mrt_pkg::is_own(mrt_pkg::NodeW'(pidx), cfg.own_node)
		&& (elapsed >= {{(32 - mrt_pkg::ThrW){1'b0}}, cfg.thr_ms});

	// announce comparison
	assign same_id = (item_q.packet_id == mem_rdata.id);
	assign better = (hops < mem_rdata.hops)
		|| ((hops == mem_rdata.hops) && (item_q.rssi > mem_rdata.rssi));
	assign ann_status = same_id ? (better ? mrt_pkg::StsBetter : mrt_pkg::StsWorse)
		: mrt_pkg::StsUpdated;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mrt_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = mrt_pkg::ST_DECODE;
				end
			end
			mrt_pkg::ST_DECODE: begin
				case (item_q.func)
					mrt_pkg::FnPacket:
						state_d = pkt_err ? mrt_pkg::ST_DONE : mrt_pkg::ST_LHOP;
					mrt_pkg::FnAnnounce:
						state_d = mrt_pkg::node_ok(item_q.sender, NodesV) ? mrt_pkg::ST_ANN
							: mrt_pkg::ST_DONE;
					mrt_pkg::FnLookup: begin
						if (item_q.destination == cfg.broadcast_addr) begin
							state_d = mrt_pkg::ST_DONE;
						end else if (mrt_pkg::node_ok(item_q.destination, NodesV)) begin
							state_d = mrt_pkg::ST_LOOK;
						end else begin
							state_d = mrt_pkg::ST_DONE;
						end
					end
					default: state_d = mrt_pkg::ST_SWEEP;
				endcase
			end
			mrt_pkg::ST_LHOP: begin
				if (!from_own && (hops != 8'd0)) begin
					state_d = mrt_pkg::ST_SEND_RD;
				end else begin
					state_d = mrt_pkg::ST_DONE;
				end
			end
			mrt_pkg::ST_SEND_RD: state_d = mrt_pkg::ST_SEND_WR;
			mrt_pkg::ST_SEND_WR: state_d = mrt_pkg::ST_DONE;
			mrt_pkg::ST_ANN: state_d = mrt_pkg::ST_DONE;
			mrt_pkg::ST_LOOK: state_d = mrt_pkg::ST_DONE;
			mrt_pkg::ST_SWEEP: begin
				if (cnt_q == CntEnd) begin
					state_d = mrt_pkg::ST_DONE;
				end
			end
			mrt_pkg::ST_DONE: begin
				if (res_take) begin
					state_d = mrt_pkg::ST_IDLE;
				end
			end
			default: state_d = mrt_pkg::ST_IDLE;
		endcase
	end

	// memory requests and handshake outputs
	always_comb begin
		mem_req = '0;
		mem_req.wr_data = mem_rdata;
		in_ready = (state_q == mrt_pkg::ST_IDLE);
		res_valid = (state_q == mrt_pkg::ST_DONE);
		case (state_q)
			mrt_pkg::ST_DECODE: begin
				case (item_q.func)
					mrt_pkg::FnPacket: begin
						mem_req.rd_en = !pkt_err;
						mem_req.rd_addr = li;
					end
					mrt_pkg::FnAnnounce: begin
						mem_req.rd_en = 1'b1;
						mem_req.rd_addr = si;
					end
					mrt_pkg::FnLookup: begin
						mem_req.rd_en = 1'b1;
						mem_req.rd_addr = di;
					end
					default: begin
						mem_req.rd_en = 1'b1;
						mem_req.rd_addr = '0;
					end
				endcase
			end
			mrt_pkg::ST_LHOP: begin
				// stamp the neighbour, learn it when new
				mem_req.wr_en = 1'b1;
				mem_req.wr_addr = li;
				mem_req.wr_data.seen = item_q.now_ms;
				mem_req.wr_data.rssi = item_q.rssi;
				if (!from_own && !li_act) begin
					mem_req.wr_data.next_hop = item_q.last_hop;
					mem_req.wr_data.hops = 8'd0;
					mem_req.wr_data.id = 16'd0;
				end
			end
			mrt_pkg::ST_SEND_RD: begin
				mem_req.rd_en = 1'b1;
				mem_req.rd_addr = si;
			end
			mrt_pkg::ST_SEND_WR: begin
				// stamp the multi-hop sender, learn it when new
				mem_req.wr_en = 1'b1;
				mem_req.wr_addr = si;
				mem_req.wr_data.seen = item_q.now_ms;
				if (!si_act) begin
					mem_req.wr_data.next_hop = item_q.last_hop;
					mem_req.wr_data.hops = hops;
					mem_req.wr_data.id = 16'd0;
				end
			end
			mrt_pkg::ST_ANN: begin
				mem_req.wr_en = !same_id || better;
				mem_req.wr_addr = si;
				mem_req.wr_data.rssi = item_q.rssi;
				mem_req.wr_data.next_hop = item_q.last_hop;
				mem_req.wr_data.hops = hops;
				mem_req.wr_data.id = item_q.packet_id;
			end
			mrt_pkg::ST_SWEEP: begin
				mem_req.rd_en = (cnt_q != CntEnd);
				mem_req.rd_addr = mrt_pkg::NodeW'(cnt_q);
			end
			default: begin
				mem_req.rd_en = 1'b0;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mrt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// active marks and sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			cnt_q <= '0;
		end else begin
			case (state_q)
				mrt_pkg::ST_DECODE: cnt_q <= CW'(1);
				mrt_pkg::ST_LHOP: begin
					if (!from_own && !li_act) begin
						active_q[li[IW-1:0]] <= 1'b1;
					end
				end
				mrt_pkg::ST_SEND_WR: begin
					if (!si_act) begin
						active_q[si[IW-1:0]] <= 1'b1;
					end
				end
				mrt_pkg::ST_SWEEP: begin
					if (retire) begin
						active_q[pidx] <= 1'b0;
					end
					if (cnt_q != CntEnd) begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// item capture and result build
	always_ff @(posedge clk) begin
		case (state_q)
			mrt_pkg::ST_IDLE: begin
				if (in_valid) begin
					item_q <= in_item;
				end
				res_q <= '0;
			end
			mrt_pkg::ST_DECODE: begin
				case (item_q.func)
					mrt_pkg::FnPacket: begin
						if (pkt_err) begin
							res_q.status <= mrt_pkg::StsError;
						end
					end
					mrt_pkg::FnAnnounce: begin
						if (!mrt_pkg::node_ok(item_q.sender, NodesV)) begin
							res_q.status <= mrt_pkg::StsError;
						end
					end
					mrt_pkg::FnLookup: begin
						if (item_q.destination == cfg.broadcast_addr) begin
							res_q.next_hop <= cfg.broadcast_addr;
						end else if (!mrt_pkg::node_ok(item_q.destination, NodesV)) begin
							res_q.status <= mrt_pkg::StsError;
						end
					end
					default: res_q <= res_q;
				endcase
			end
			mrt_pkg::ST_LHOP: begin
				if (from_own) begin
					res_q.status <= mrt_pkg::StsError;
				end
			end
			mrt_pkg::ST_ANN: res_q.status <= ann_status;
			mrt_pkg::ST_LOOK: begin
				res_q.is_active <= di_act;
				res_q.next_hop <= di_act ? mem_rdata.next_hop : 8'd0;
				res_q.hop_count <= mem_rdata.hops;
				res_q.link_rssi <= mem_rdata.rssi;
				res_q.seen_id <= mem_rdata.id;
			end
			mrt_pkg::ST_SWEEP: begin
				// saturating count of retired nodes
				if (retire && (res_q.removed_count != 5'd31)) begin
					res_q.removed_count <= res_q.removed_count + 5'd1;
				end
			end
			default: res_q <= res_q;
		endcase
	end

	assign res = res_q;

endmodule

@@ src/mesh_route_table_top.sv @@
// route table top level: configuration registers, stream ports and output register
// one item is in work at a time: a new item is accepted only once the previous result
// has moved into the output register; items run read and write-back sequences over the
// route memory, which has one write and one registered read port (a sweep reads one
// entry a cycle)
// reset: arst_n clears configuration to its defaults, all active and written marks,
// the sequencer and the output valid flag at once; no clearing pass is needed
module mesh_route_table_top #(
	parameter int NODES = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// sender, last_hop, ttl, packet_id, rssi, now_ms, destination, zero pad
	input  logic [mrt_pkg::InBits-1:0] s_tdata,
	// func
	input  logic [1:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// status, next_hop, hop_count, link_rssi, seen_id, is_active, removed_count, zero pad
	output logic [mrt_pkg::OutBits-1:0] m_tdata,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_wdata
);
	mrt_pkg::cfg_t cfg_q;
	mrt_pkg::item_t in_item;
	mrt_pkg::result_t res;
	mrt_pkg::result_t m_data_q;
	logic m_valid_q;
	logic res_valid;
	logic res_take;
	mrt_pkg::mem_req_t mem_req;
	mrt_pkg::route_entry_t mem_rdata;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_node <= mrt_pkg::OwnNodeReset;
			cfg_q.ttl_start <= mrt_pkg::TtlStartReset;
			cfg_q.thr_ms <= mrt_pkg::ThrReset;
			cfg_q.broadcast_addr <= mrt_pkg::BroadcastReset;
		end else if (cfg_we) begin
			case (cfg_index)
				mrt_pkg::CfgOwnNode: cfg_q.own_node <= cfg_wdata[4:0];
				mrt_pkg::CfgTtlStart: cfg_q.ttl_start <= cfg_wdata;
				mrt_pkg::CfgInactive:
					cfg_q.thr_ms <= mrt_pkg::ThrW'(32'(cfg_wdata) * mrt_pkg::MsPerMin);
				mrt_pkg::CfgBroadcast: cfg_q.broadcast_addr <= cfg_wdata;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// input unpacking
	assign in_item = {s_tuser, s_tdata[$bits(mrt_pkg::item_t)-3:0]};

	mrt_seq #(
		.NODES(NODES)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_item(in_item),
		.cfg(cfg_q),
		.res_valid(res_valid),
		.res_take(res_take),
		.res(res),
		.mem_req(mem_req),
		.mem_rdata(mem_rdata)
	);

	mrt_store #(
		.NODES(NODES)
	) u_store (
		.clk(clk),
		.arst_n(arst_n),
		.req(mem_req),
		.rd_data(mem_rdata)
	);

	// output register, refilled as the previous item leaves
	assign res_take = res_valid && (!m_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_take) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			m_data_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = mrt_pkg::OutBits'(m_data_q);

endmodule

@@ src/mrt_checker.sv @@
// port-level checks of the route table, bound to the top level
module mrt_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [mrt_pkg::OutBits-1:0] m_tdata
);

	// a stalled result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// a stalled result holds its value
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	// one item at a time: input closes right after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item accepted while busy");

	// a fresh result only follows a busy cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared without an item in work");

endmodule

bind mesh_route_table_top mrt_checker u_mrt_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);
